// ===== hdl/tbps_pkg.sv =====
`timescale 1ns / 1ps

package tbps_pkg;

	// Coordinate width after optional doubling (0..30)
	localparam int unsigned CoordW = 5;
	// Partition sums are kept modulo 64
	localparam int unsigned SumW = 6;
	// Seed offset step per partition count
	localparam int unsigned SeedStepLog2 = 10;

	typedef logic [31:0] word_t;
	typedef logic [2:0] shamt_t;
	typedef logic [SumW-1:0] sum_t;
	typedef logic [CoordW-1:0] coord_t;

	// Per-item control carried along the pipe
	typedef struct packed {
		shamt_t sh1;
		shamt_t sh2;
		shamt_t sh3;
		logic   zero2;   // count below 3: sum 2 unused
		logic   zero3;   // count below 4: sum 3 unused
	} sel_ctl_t;

	// First half of the integer hash (two carry chains)
	function automatic word_t mix_lo(input word_t v);
		word_t a;
		a = v ^ (v >> 15);
		a = a - (a << 17);
		a = a + (a << 7);
		return a;
	endfunction

	// Second half of the integer hash (two carry chains)
	function automatic word_t mix_hi(input word_t v);
		word_t a;
		a = v + (v << 4);
		a = a ^ (a >> 5);
		a = a + (a << 16);
		a = a ^ (a >> 7);
		a = a ^ (a >> 3);
		a = a ^ (a << 6);
		a = a ^ (a >> 17);
		return a;
	endfunction

	// Squared nibble shifted right by 4..6; result fits in 4 bits
	function automatic logic [3:0] sq_shift(input logic [3:0] nib, input shamt_t sh);
		logic [7:0] sq;
		logic [7:0] shifted;
		sq      = 8'(nib * nib);
		shifted = sq >> sh;
		return shifted[3:0];
	endfunction

	// Weight times coordinate, modulo 64
	function automatic sum_t wmul(input logic [3:0] w, input coord_t c);
		logic [8:0] p;
		p = 9'(w * c);
		return p[SumW-1:0];
	endfunction

endpackage

// ===== hdl/texture_block_partition_select.sv =====
`timescale 1ns / 1ps

// ASTC partition selection for one texel per transaction. Each accepted texel
// (pattern index, partition count, x/y/z) yields one partition index 0..3.
// The block takes a new texel every cycle while the result side is ready;
// the result is registered through five pipeline registers: seed and
// coordinate capture, two halves of the 32-bit seed hash, the twelve
// weight-by-coordinate products, and the sum/argmax output register.
// Stalls on the result side back up stage by stage, and empty stages keep
// accepting, so no transaction is lost or repeated. small_footprint
// doubles the coordinates; write it only while the pipeline is empty.
module texture_block_partition_select
	import tbps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	// texel input
	input  logic       texel_valid,
	output logic       texel_ready,
	input  logic [9:0] pattern_index,
	input  logic [2:0] part_count,
	input  logic [3:0] texel_x,
	input  logic [3:0] texel_y,
	input  logic [3:0] texel_z,
	// result output
	output logic       part_valid,
	input  logic       part_ready,
	output logic [1:0] partition
);

	logic small_footprint_q;

	// stage valids and per-stage ready
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// stage payloads
	word_t    seed_s1;
	logic [2:0] cnt_s1;
	coord_t   x_s1, y_s1, z_s1;

	word_t    h_s2;
	sel_ctl_t ctl_s2;
	coord_t   x_s2, y_s2, z_s2;

	word_t    h_s3;
	sel_ctl_t ctl_s3;
	coord_t   x_s3, y_s3, z_s3;

	sum_t     px_s4 [4];
	sum_t     py_s4 [4];
	sum_t     pz_s4 [4];
	sum_t     off_s4 [4];
	sel_ctl_t ctl_s4;

	logic [1:0] part_s5;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_footprint_q <= 1'b0;
		end else if (cfg_we) begin
			small_footprint_q <= cfg_wdata;
		end
	end

	// ready chain: a stage loads when it is empty or its content moves on
	assign rdy5        = !v_s5 || part_ready;
	assign rdy4        = !v_s4 || rdy5;
	assign rdy3        = !v_s3 || rdy4;
	assign rdy2        = !v_s2 || rdy3;
	assign rdy1        = !v_s1 || rdy2;
	assign texel_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= texel_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: seed and coordinates
	word_t  seed_c;
	coord_t x_c, y_c, z_c;

	always_comb begin
		seed_c = {22'd0, pattern_index}
			+ ((word_t'(part_count) - word_t'(1)) << SeedStepLog2);
		x_c = small_footprint_q ? {texel_x, 1'b0} : {1'b0, texel_x};
		y_c = small_footprint_q ? {texel_y, 1'b0} : {1'b0, texel_y};
		z_c = small_footprint_q ? {texel_z, 1'b0} : {1'b0, texel_z};
	end

	always_ff @(posedge clk) begin
		if (rdy1 && texel_valid) begin
			seed_s1 <= seed_c;
			cnt_s1  <= part_count;
			x_s1    <= x_c;
			y_s1    <= y_c;
			z_s1    <= z_c;
		end
	end

	// stage 2: first hash half and shift selection
	sel_ctl_t ctl_c;
	shamt_t   sh_odd, sh_cnt;

	always_comb begin
		sh_odd = seed_s1[1] ? 3'd4 : 3'd5;
		sh_cnt = (cnt_s1 == 3'd3) ? 3'd6 : 3'd5;
		if (seed_s1[0]) begin
			ctl_c.sh1 = sh_odd;
			ctl_c.sh2 = sh_cnt;
		end else begin
			ctl_c.sh1 = sh_cnt;
			ctl_c.sh2 = sh_odd;
		end
		ctl_c.sh3   = seed_s1[4] ? ctl_c.sh1 : ctl_c.sh2;
		ctl_c.zero2 = cnt_s1 < 3'd3;
		ctl_c.zero3 = cnt_s1 < 3'd4;
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			h_s2   <= mix_lo(seed_s1);
			ctl_s2 <= ctl_c;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
		end
	end

	// stage 3: second hash half
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			h_s3   <= mix_hi(h_s2);
			ctl_s3 <= ctl_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
		end
	end

	// stage 4: squared-nibble weights times coordinates
	logic [3:0] wx [4];
	logic [3:0] wy [4];
	logic [3:0] wz [4];
	sum_t       off_c [4];

	always_comb begin
		wx[0] = sq_shift(h_s3[3:0],   ctl_s3.sh1);
		wy[0] = sq_shift(h_s3[7:4],   ctl_s3.sh2);
		wz[0] = sq_shift(h_s3[29:26], ctl_s3.sh3);
		wx[1] = sq_shift(h_s3[11:8],  ctl_s3.sh1);
		wy[1] = sq_shift(h_s3[15:12], ctl_s3.sh2);
		wz[1] = sq_shift({h_s3[1:0], h_s3[31:30]}, ctl_s3.sh3);
		wx[2] = sq_shift(h_s3[19:16], ctl_s3.sh1);
		wy[2] = sq_shift(h_s3[23:20], ctl_s3.sh2);
		wz[2] = sq_shift(h_s3[21:18], ctl_s3.sh3);
		wx[3] = sq_shift(h_s3[27:24], ctl_s3.sh1);
		wy[3] = sq_shift(h_s3[31:28], ctl_s3.sh2);
		wz[3] = sq_shift(h_s3[25:22], ctl_s3.sh3);
		off_c[0] = h_s3[19:14];
		off_c[1] = h_s3[15:10];
		off_c[2] = h_s3[11:6];
		off_c[3] = h_s3[7:2];
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			for (int i = 0; i < 4; i++) begin
				px_s4[i]  <= wmul(wx[i], x_s3);
				py_s4[i]  <= wmul(wy[i], y_s3);
				pz_s4[i]  <= wmul(wz[i], z_s3);
				off_s4[i] <= off_c[i];
			end
			ctl_s4 <= ctl_s3;
		end
	end

	// stage 5: sums modulo 64, unused sums cleared, argmax with low-index ties
	sum_t       s [4];
	logic [1:0] part_c;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			s[i] = px_s4[i] + py_s4[i] + pz_s4[i] + off_s4[i];
		end
		if (ctl_s4.zero3) s[3] = '0;
		if (ctl_s4.zero2) s[2] = '0;

		if (s[0] >= s[1] && s[0] >= s[2] && s[0] >= s[3]) begin
			part_c = 2'd0;
		end else if (s[1] >= s[2] && s[1] >= s[3]) begin
			part_c = 2'd1;
		end else if (s[2] >= s[3]) begin
			part_c = 2'd2;
		end else begin
			part_c = 2'd3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			part_s5 <= part_c;
		end
	end

	assign part_valid = v_s5;
	assign partition  = part_s5;

endmodule

// ===== dv/texture_block_partition_select_tb.sv =====
`timescale 1ns / 1ps

module texture_block_partition_select_tb;

	// One texel as presented on the input channel
	typedef struct {
		logic [9:0] pat;
		logic [2:0] cnt;
		logic [3:0] x;
		logic [3:0] y;
		logic [3:0] z;
	} texel_t;

	// Expected partition, with the texel and footprint mode for reporting
	typedef struct {
		texel_t     t;
		logic       doubled;
		logic [1:0] part;
	} part_exp_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       texel_valid = 1'b0;
	logic       texel_ready;
	logic [9:0] pattern_index = '0;
	logic [2:0] part_count = '0;
	logic [3:0] texel_x = '0;
	logic [3:0] texel_y = '0;
	logic [3:0] texel_z = '0;
	logic       part_valid;
	logic       part_ready = 1'b0;
	logic [1:0] partition;

	texel_t    pending_texels[$];
	part_exp_t expected_parts[$];

	// Model copy of the footprint register
	logic footprint_doubled = 1'b0;

	// Idle and hold-off controls, set between phases
	logic tx_idle_en = 1'b0;
	logic rx_idle_en = 1'b0;
	int   long_hold_req = 0;

	int errors = 0;
	int checked_count = 0;
	int doubled_count = 0;
	int seen_part[4] = '{0, 0, 0, 0};

	texture_block_partition_select DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.texel_valid  (texel_valid),
		.texel_ready  (texel_ready),
		.pattern_index(pattern_index),
		.part_count   (part_count),
		.texel_x      (texel_x),
		.texel_y      (texel_y),
		.texel_z      (texel_z),
		.part_valid   (part_valid),
		.part_ready   (part_ready),
		.partition    (partition)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hash nibble squared, then scaled down by the selected shift
	function automatic logic [31:0] hash_weight(input logic [3:0] nib, input logic [2:0] sh);
		logic [7:0] sq;
		sq = nib * nib;
		return 32'(sq >> sh);
	endfunction

	// Partition of one texel under the hash52 selection scheme
	function automatic logic [1:0] predict_partition(input texel_t t, input logic doubled);
		logic [31:0] seed;
		logic [31:0] h;
		logic [31:0] xc;
		logic [31:0] yc;
		logic [31:0] zc;
		logic [31:0] acc;
		logic [2:0]  sh1;
		logic [2:0]  sh2;
		logic [2:0]  sh3;
		logic [5:0]  m0;
		logic [5:0]  m1;
		logic [5:0]  m2;
		logic [5:0]  m3;
		xc = doubled ? {27'd0, t.x, 1'b0} : {28'd0, t.x};
		yc = doubled ? {27'd0, t.y, 1'b0} : {28'd0, t.y};
		zc = doubled ? {27'd0, t.z, 1'b0} : {28'd0, t.z};

		// seed wraps for a count of zero
		seed = 32'(t.pat) + (32'(t.cnt) - 32'd1) * 32'd1024;
		h = seed;
		h = h ^ (h >> 15);
		h = h - (h << 17);
		h = h + (h << 7);
		h = h + (h << 4);
		h = h ^ (h >> 5);
		h = h + (h << 16);
		h = h ^ (h >> 7);
		h = h ^ (h >> 3);
		h = h ^ (h << 6);
		h = h ^ (h >> 17);

		// shift selection from seed bits and the three-partition case
		if (seed[0]) begin
			sh1 = seed[1] ? 3'd4 : 3'd5;
			sh2 = (t.cnt == 3'd3) ? 3'd6 : 3'd5;
		end else begin
			sh1 = (t.cnt == 3'd3) ? 3'd6 : 3'd5;
			sh2 = seed[1] ? 3'd4 : 3'd5;
		end
		sh3 = seed[4] ? sh1 : sh2;

		// four weighted sums, modulo 64
		acc = hash_weight(h[3:0], sh1) * xc + hash_weight(h[7:4], sh2) * yc
			+ hash_weight(h[29:26], sh3) * zc + (h >> 14);
		m0 = acc[5:0];
		acc = hash_weight(h[11:8], sh1) * xc + hash_weight(h[15:12], sh2) * yc
			+ hash_weight({h[1:0], h[31:30]}, sh3) * zc + (h >> 10);
		m1 = acc[5:0];
		acc = hash_weight(h[19:16], sh1) * xc + hash_weight(h[23:20], sh2) * yc
			+ hash_weight(h[21:18], sh3) * zc + (h >> 6);
		m2 = acc[5:0];
		acc = hash_weight(h[27:24], sh1) * xc + hash_weight(h[31:28], sh2) * yc
			+ hash_weight(h[25:22], sh3) * zc + (h >> 2);
		m3 = acc[5:0];

		// unused partitions drop out
		if (t.cnt < 3'd4) begin
			m3 = '0;
		end
		if (t.cnt < 3'd3) begin
			m2 = '0;
		end

		// largest sum wins, lower index on ties
		if (m0 >= m1 && m0 >= m2 && m0 >= m3) begin
			return 2'd0;
		end else if (m1 >= m2 && m1 >= m3) begin
			return 2'd1;
		end else if (m2 >= m3) begin
			return 2'd2;
		end
		return 2'd3;
	endfunction

	// Input driver: presents queued texels, random gaps when enabled
	always @(posedge clk or negedge arst_n) begin : texel_driver
		logic      accepted;
		texel_t    t;
		part_exp_t e;
		int        tx_gap;
		if (!arst_n) begin
			texel_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			accepted = texel_valid && texel_ready;
			if (accepted) begin
				e.t.pat = pattern_index;
				e.t.cnt = part_count;
				e.t.x = texel_x;
				e.t.y = texel_y;
				e.t.z = texel_z;
				e.doubled = footprint_doubled;
				e.part = predict_partition(e.t, footprint_doubled);
				expected_parts.push_back(e);
			end
			if (texel_valid && !accepted) begin
				// hold the offered transaction
			end else if (tx_gap > 0) begin
				tx_gap--;
				texel_valid <= 1'b0;
			end else if (tx_idle_en && pending_texels.size() != 0
					&& $urandom_range(0, 7) == 0) begin
				tx_gap = $urandom_range(1, 18) - 1;
				texel_valid <= 1'b0;
			end else if (pending_texels.size() != 0) begin
				t = pending_texels.pop_front();
				pattern_index <= t.pat;
				part_count <= t.cnt;
				texel_x <= t.x;
				texel_y <= t.y;
				texel_z <= t.z;
				texel_valid <= 1'b1;
			end else begin
				texel_valid <= 1'b0;
			end
		end
	end

	// Result monitor: checks each partition, drives ready with stalls
	always @(posedge clk or negedge arst_n) begin : part_monitor
		part_exp_t e;
		int        rx_stall;
		int        hold_left;
		int        long_hold_done;
		if (!arst_n) begin
			part_ready <= 1'b0;
			rx_stall = 0;
			hold_left = 0;
			long_hold_done = 0;
		end else begin
			if (part_valid && part_ready) begin
				if (expected_parts.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("ERROR: partition %0d with no texel outstanding", partition);
					end
				end else begin
					e = expected_parts.pop_front();
					checked_count++;
					if (e.doubled) begin
						doubled_count++;
					end
					seen_part[e.part]++;
					if (partition !== e.part) begin
						errors++;
						if (errors <= 10) begin
							$display("ERROR: pat=%0d cnt=%0d xyz=%0d,%0d,%0d dbl=%0d exp=%0d got=%0d",
								e.t.pat, e.t.cnt, e.t.x, e.t.y, e.t.z, e.doubled,
								e.part, partition);
						end
					end
				end
			end

			// long hold-off on request, else random stall bursts
			if (long_hold_req != long_hold_done) begin
				long_hold_done = long_hold_req;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				part_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				part_ready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				rx_stall = $urandom_range(1, 18) - 1;
				part_ready <= 1'b0;
			end else begin
				part_ready <= 1'b1;
			end
		end
	end

	task automatic queue_texel(input int pat, input int cnt, input int x, input int y,
			input int z);
		texel_t t;
		t.pat = 10'(pat);
		t.cnt = 3'(cnt);
		t.x = 4'(x);
		t.y = 4'(y);
		t.z = 4'(z);
		pending_texels.push_back(t);
	endtask

	// Random texels: mostly nominal counts, some out-of-range counts and edge coords
	task automatic queue_random_texels(input int n);
		texel_t t;
		for (int i = 0; i < n; i++) begin
			t.pat = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
				: 10'($urandom_range(0, 1023));
			if ($urandom_range(0, 9) == 0) begin
				t.cnt = ($urandom_range(0, 3) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
			end else begin
				t.cnt = 3'($urandom_range(1, 4));
			end
			t.x = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 1) * 15)
				: 4'($urandom_range(0, 15));
			t.y = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 1) * 15)
				: 4'($urandom_range(0, 15));
			t.z = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 1) * 15)
				: 4'($urandom_range(0, 15));
			pending_texels.push_back(t);
		end
	endtask

	// Wait until every queued texel is sent and every partition is back
	task automatic wait_drained;
		@(negedge clk);
		while (pending_texels.size() != 0 || texel_valid || expected_parts.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Footprint register write; only called with the pipeline empty
	task automatic write_footprint(input logic v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		footprint_doubled = v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Stimulus sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes, every count, seed bits picking the shifts
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		write_footprint(1'b0);
		queue_texel(0, 1, 0, 0, 0);
		queue_texel(1023, 4, 15, 15, 15);
		queue_texel(0, 0, 15, 15, 15);
		queue_texel(1023, 0, 0, 0, 0);
		queue_texel(512, 5, 15, 0, 15);
		queue_texel(1, 6, 0, 15, 0);
		queue_texel(1022, 7, 15, 15, 15);
		queue_texel('h001, 3, 7, 9, 3);
		queue_texel('h002, 3, 15, 15, 0);
		queue_texel('h003, 2, 15, 0, 15);
		queue_texel('h010, 3, 3, 15, 8);
		queue_texel('h013, 4, 15, 15, 15);
		queue_texel('h011, 1, 9, 9, 9);
		queue_texel('h012, 2, 15, 15, 15);
		queue_texel('h3EF, 3, 0, 15, 15);
		queue_texel('h155, 4, 10, 5, 10);
		wait_drained();

		// directed with doubled coordinates
		write_footprint(1'b1);
		queue_texel(0, 4, 15, 15, 15);
		queue_texel(1023, 3, 15, 15, 15);
		queue_texel('h013, 2, 15, 15, 15);
		queue_texel('h2AA, 1, 15, 15, 15);
		queue_texel(0, 0, 15, 15, 15);
		queue_texel(1023, 7, 15, 15, 15);
		queue_texel('h001, 3, 8, 8, 8);
		queue_texel('h002, 4, 1, 2, 3);
		wait_drained();

		// random phases; the last one runs without idling
		for (int ph = 0; ph < 6; ph++) begin
			write_footprint(ph == 1 || ph == 2 || ph == 4);
			tx_idle_en = (ph < 5);
			rx_idle_en = (ph < 5) && (ph != 2);
			if (ph == 1 || ph == 3) begin
				long_hold_req++;
			end
			queue_random_texels(113);
			wait_drained();
		end

		repeat (16) @(posedge clk);
		@(negedge clk);
		errors += expected_parts.size();

		$display("Run covered %0d texels (%0d with doubled coordinates), part counts 0 to 7",
			checked_count, doubled_count);
		$display("Partitions seen 0/1/2/3: %0d/%0d/%0d/%0d, failures: %0d",
			seen_part[0], seen_part[1], seen_part[2], seen_part[3], errors);
		if (errors == 0) begin
			$display("PASS texture_block_partition_select");
		end else begin
			$display("FAIL texture_block_partition_select");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("FAIL texture_block_partition_select");
		$finish;
	end

endmodule
